// File: design/sgi_pkg.sv
// Shared widths, register map and stage types for the segment intersection pipeline.
package sgi_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 8;
    localparam int CROSS_W   = 24;
    localparam int LIMIT_W   = 16;
    localparam int DATA_W    = 32;

    localparam int REG_IDX_W = 1;
    localparam int ADDR_W    = REG_IDX_W + 2;
    localparam logic [REG_IDX_W-1:0] REG_PARALLEL_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET        = LIMIT_W'(66);

    // differences, products, cross terms
    localparam int D_W    = COORD_W + 1;
    localparam int PROD_W = 2 * D_W;
    localparam int CP_W   = PROD_W + 1;
    localparam int MAG_W  = PROD_W;
    localparam int HALF_W = MAG_W / 2;
    localparam int HI_W   = MAG_W - HALF_W;
    localparam int PP_W   = D_W + HI_W + 1;
    localparam int SUM_W  = PP_W + 1;
    localparam int DD_W   = MAG_W + FRAC_BITS;

    // quotient magnitude bits and numerator width
    localparam int QN_W  = COORD_W - FRAC_BITS + 1;
    localparam int Q_W   = (QN_W > CROSS_W) ? QN_W : CROSS_W;
    localparam int NUM_A = 3 * COORD_W + 6;
    localparam int NUM_B = DD_W + Q_W + 1;
    localparam int NUM_W = (NUM_A > NUM_B) ? NUM_A : NUM_B;

    typedef struct packed {
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [COORD_W-1:0] p2_x;
        logic signed [COORD_W-1:0] p2_y;
        logic signed [COORD_W-1:0] q1_x;
        logic signed [COORD_W-1:0] q1_y;
        logic signed [COORD_W-1:0] q2_x;
        logic signed [COORD_W-1:0] q2_y;
    } seg_pair_t;

    typedef struct packed {
        logic                      valid;
        logic                      hit;
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [D_W-1:0]     dp_x;
        logic signed [D_W-1:0]     dp_y;
        logic        [MAG_W-1:0]   den;
        logic        [MAG_W-1:0]   na;
    } cross_res_t;

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic             neg_x;
        logic             neg_y;
        logic [DD_W-1:0]  dd;
        logic [NUM_W-1:0] rem_x;
        logic [NUM_W-1:0] rem_y;
        logic [Q_W-1:0]   q_x;
        logic [Q_W-1:0]   q_y;
    } div_stage_t;

endpackage

// File: design/sgi_cross.sv
// Front stages: differences, cross products, sign fix and hit test.
module sgi_cross import sgi_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  seg_pair_t          in_pair,
    input  logic [LIMIT_W-1:0] limit,
    output cross_res_t         res
);

    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [D_W-1:0]     dp_x;
        logic signed [D_W-1:0]     dp_y;
        logic signed [D_W-1:0]     dq_x;
        logic signed [D_W-1:0]     dq_y;
        logic signed [D_W-1:0]     r_x;
        logic signed [D_W-1:0]     r_y;
    } st1_t;

    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [D_W-1:0]     dp_x;
        logic signed [D_W-1:0]     dp_y;
        logic signed [PROD_W-1:0]  m0;
        logic signed [PROD_W-1:0]  m1;
        logic signed [PROD_W-1:0]  m2;
        logic signed [PROD_W-1:0]  m3;
        logic signed [PROD_W-1:0]  m4;
        logic signed [PROD_W-1:0]  m5;
    } st2_t;

    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [D_W-1:0]     dp_x;
        logic signed [D_W-1:0]     dp_y;
        logic signed [CP_W-1:0]    den;
        logic signed [CP_W-1:0]    na;
        logic signed [CP_W-1:0]    nb;
    } st3_t;

    st1_t       s1_next, s1_reg;
    st2_t       s2_next, s2_reg;
    st3_t       s3_next, s3_reg;
    st3_t       s4_next, s4_reg;
    cross_res_t s5_next, s5_reg;
    logic signed [CP_W-1:0] lim_s;

    always_comb begin
        s1_next.valid = in_valid;
        s1_next.p1_x  = in_pair.p1_x;
        s1_next.p1_y  = in_pair.p1_y;
        s1_next.dp_x  = D_W'(in_pair.p2_x) - D_W'(in_pair.p1_x);
        s1_next.dp_y  = D_W'(in_pair.p2_y) - D_W'(in_pair.p1_y);
        s1_next.dq_x  = D_W'(in_pair.q2_x) - D_W'(in_pair.q1_x);
        s1_next.dq_y  = D_W'(in_pair.q2_y) - D_W'(in_pair.q1_y);
        s1_next.r_x   = D_W'(in_pair.p1_x) - D_W'(in_pair.q1_x);
        s1_next.r_y   = D_W'(in_pair.p1_y) - D_W'(in_pair.q1_y);
    end

    always_comb begin
        s2_next.valid = s1_reg.valid;
        s2_next.p1_x  = s1_reg.p1_x;
        s2_next.p1_y  = s1_reg.p1_y;
        s2_next.dp_x  = s1_reg.dp_x;
        s2_next.dp_y  = s1_reg.dp_y;
        s2_next.m0    = s1_reg.dq_y * s1_reg.dp_x;
        s2_next.m1    = s1_reg.dq_x * s1_reg.dp_y;
        s2_next.m2    = s1_reg.dq_x * s1_reg.r_y;
        s2_next.m3    = s1_reg.dq_y * s1_reg.r_x;
        s2_next.m4    = s1_reg.dp_x * s1_reg.r_y;
        s2_next.m5    = s1_reg.dp_y * s1_reg.r_x;
    end

    always_comb begin
        s3_next.valid = s2_reg.valid;
        s3_next.p1_x  = s2_reg.p1_x;
        s3_next.p1_y  = s2_reg.p1_y;
        s3_next.dp_x  = s2_reg.dp_x;
        s3_next.dp_y  = s2_reg.dp_y;
        s3_next.den   = CP_W'(s2_reg.m0) - CP_W'(s2_reg.m1);
        s3_next.na    = CP_W'(s2_reg.m2) - CP_W'(s2_reg.m3);
        s3_next.nb    = CP_W'(s2_reg.m4) - CP_W'(s2_reg.m5);
    end

    // make the denominator non-negative so the range test is plain compares
    always_comb begin
        s4_next = s3_reg;
        if (s3_reg.den[CP_W-1]) begin
            s4_next.den = -s3_reg.den;
            s4_next.na  = -s3_reg.na;
            s4_next.nb  = -s3_reg.nb;
        end
    end

    assign lim_s = {{(CP_W-LIMIT_W){1'b0}}, limit};

    always_comb begin
        s5_next.valid = s4_reg.valid;
        s5_next.hit   = (s4_reg.den != '0) && (s4_reg.den >= lim_s) &&
                        !s4_reg.na[CP_W-1] && !s4_reg.nb[CP_W-1] &&
                        (s4_reg.na <= s4_reg.den) && (s4_reg.nb <= s4_reg.den);
        s5_next.p1_x  = s4_reg.p1_x;
        s5_next.p1_y  = s4_reg.p1_y;
        s5_next.dp_x  = s4_reg.dp_x;
        s5_next.dp_y  = s4_reg.dp_y;
        s5_next.den   = s4_reg.den[MAG_W-1:0];
        s5_next.na    = s4_reg.na[MAG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
            s2_reg.valid <= 1'b0;
            s3_reg.valid <= 1'b0;
            s4_reg.valid <= 1'b0;
            s5_reg.valid <= 1'b0;
        end else if (en) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
        end
    end

    assign res = s5_reg;

endmodule

// File: design/sgi_point.sv
// Crossing point numerators from split partial products, then sign and magnitude.
module sgi_point import sgi_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  cross_res_t c,
    output div_stage_t d
);

    typedef struct packed {
        logic                    valid;
        logic                    hit;
        logic [MAG_W-1:0]        den;
        logic signed [PP_W-1:0]  a0x;
        logic signed [PP_W-1:0]  a1x;
        logic signed [PP_W-1:0]  a0y;
        logic signed [PP_W-1:0]  a1y;
        logic signed [PP_W-1:0]  b0x;
        logic signed [PP_W-1:0]  b1x;
        logic signed [PP_W-1:0]  b0y;
        logic signed [PP_W-1:0]  b1y;
    } st6_t;

    typedef struct packed {
        logic                    valid;
        logic                    hit;
        logic [MAG_W-1:0]        den;
        logic signed [SUM_W-1:0] hx;
        logic signed [SUM_W-1:0] lx;
        logic signed [SUM_W-1:0] hy;
        logic signed [SUM_W-1:0] ly;
    } st7_t;

    typedef struct packed {
        logic                    valid;
        logic                    hit;
        logic [DD_W-1:0]         dd;
        logic signed [NUM_W-1:0] nx;
        logic signed [NUM_W-1:0] ny;
    } st8_t;

    st6_t       s6_next, s6_reg;
    st7_t       s7_next, s7_reg;
    st8_t       s8_next, s8_reg;
    div_stage_t d_next, d_reg;

    logic signed [HALF_W:0] den_lo, na_lo;
    logic signed [HI_W:0]   den_hi, na_hi;

    assign den_lo = {1'b0, c.den[HALF_W-1:0]};
    assign den_hi = {1'b0, c.den[MAG_W-1:HALF_W]};
    assign na_lo  = {1'b0, c.na[HALF_W-1:0]};
    assign na_hi  = {1'b0, c.na[MAG_W-1:HALF_W]};

    // n = p1*den + na*dp, with den and na cut into low and high halves
    always_comb begin
        s6_next.valid = c.valid;
        s6_next.hit   = c.hit;
        s6_next.den   = c.den;
        s6_next.a0x   = c.p1_x * den_lo;
        s6_next.a1x   = c.p1_x * den_hi;
        s6_next.a0y   = c.p1_y * den_lo;
        s6_next.a1y   = c.p1_y * den_hi;
        s6_next.b0x   = c.dp_x * na_lo;
        s6_next.b1x   = c.dp_x * na_hi;
        s6_next.b0y   = c.dp_y * na_lo;
        s6_next.b1y   = c.dp_y * na_hi;
    end

    always_comb begin
        s7_next.valid = s6_reg.valid;
        s7_next.hit   = s6_reg.hit;
        s7_next.den   = s6_reg.den;
        s7_next.hx    = SUM_W'(s6_reg.a1x) + SUM_W'(s6_reg.b1x);
        s7_next.lx    = SUM_W'(s6_reg.a0x) + SUM_W'(s6_reg.b0x);
        s7_next.hy    = SUM_W'(s6_reg.a1y) + SUM_W'(s6_reg.b1y);
        s7_next.ly    = SUM_W'(s6_reg.a0y) + SUM_W'(s6_reg.b0y);
    end

    always_comb begin
        s8_next.valid = s7_reg.valid;
        s8_next.hit   = s7_reg.hit;
        s8_next.dd    = DD_W'(s7_reg.den) << FRAC_BITS;
        s8_next.nx    = (NUM_W'(s7_reg.hx) <<< HALF_W) + NUM_W'(s7_reg.lx);
        s8_next.ny    = (NUM_W'(s7_reg.hy) <<< HALF_W) + NUM_W'(s7_reg.ly);
    end

    always_comb begin
        d_next.valid = s8_reg.valid;
        d_next.hit   = s8_reg.hit;
        d_next.dd    = s8_reg.dd;
        d_next.neg_x = s8_reg.nx[NUM_W-1];
        d_next.neg_y = s8_reg.ny[NUM_W-1];
        d_next.rem_x = s8_reg.nx[NUM_W-1] ? -s8_reg.nx : s8_reg.nx;
        d_next.rem_y = s8_reg.ny[NUM_W-1] ? -s8_reg.ny : s8_reg.ny;
        d_next.q_x   = '0;
        d_next.q_y   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_reg.valid <= 1'b0;
            s7_reg.valid <= 1'b0;
            s8_reg.valid <= 1'b0;
            d_reg.valid  <= 1'b0;
        end else if (en) begin
            s6_reg <= s6_next;
            s7_reg <= s7_next;
            s8_reg <= s8_next;
            d_reg  <= d_next;
        end
    end

    assign d = d_reg;

endmodule

// File: design/sgi_div.sv
// Restoring divider, one quotient bit per stage for both coordinates.
module sgi_div import sgi_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  div_stage_t d_in,
    output div_stage_t d_out
);

    div_stage_t st_reg [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        localparam int K = Q_W - 1 - j;
        div_stage_t       src, st_next;
        logic [NUM_W-1:0] sh;
        logic [NUM_W:0]   dx, dy;

        if (j == 0) begin : g_src_first
            assign src = d_in;
        end else begin : g_src_chain
            assign src = st_reg[j-1];
        end

        assign sh = NUM_W'(src.dd) << K;
        assign dx = {1'b0, src.rem_x} - {1'b0, sh};
        assign dy = {1'b0, src.rem_y} - {1'b0, sh};

        always_comb begin
            st_next = src;
            if (!dx[NUM_W]) begin
                st_next.rem_x  = dx[NUM_W-1:0];
                st_next.q_x[K] = 1'b1;
            end
            if (!dy[NUM_W]) begin
                st_next.rem_y  = dy[NUM_W-1:0];
                st_next.q_y[K] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_reg[j].valid <= 1'b0;
            end else if (en) begin
                st_reg[j] <= st_next;
            end
        end
    end

    assign d_out = st_reg[Q_W-1];

endmodule

// File: design/sgi_out.sv
// Result formatting, output register and skid stage; drives the pipeline enable.
module sgi_out import sgi_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  div_stage_t                d,
    output logic                      en,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_hit,
    output logic signed [CROSS_W-1:0] m_cross_x,
    output logic signed [CROSS_W-1:0] m_cross_y
);

    typedef struct packed {
        logic                 hit;
        logic [CROSS_W-1:0]   cross_x;
        logic [CROSS_W-1:0]   cross_y;
    } result_t;

    result_t        fin;
    result_t        out_next, out_reg, skid_next, skid_reg;
    logic           out_valid_next, out_valid_reg, skid_valid_next, skid_valid_reg;
    logic [Q_W-1:0] qx, qy;

    assign qx = d.neg_x ? -d.q_x : d.q_x;
    assign qy = d.neg_y ? -d.q_y : d.q_y;

    always_comb begin
        fin.hit     = d.hit;
        fin.cross_x = d.hit ? qx[CROSS_W-1:0] : '0;
        fin.cross_y = d.hit ? qy[CROSS_W-1:0] : '0;
    end

    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!skid_valid_reg) begin
            if (!out_valid_reg || m_ready) begin
                out_valid_next = d.valid;
                out_next       = fin;
            end else if (d.valid) begin
                // output is stalled: park the arriving result
                skid_valid_next = 1'b1;
                skid_next       = fin;
            end
        end else if (m_ready) begin
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign en        = !skid_valid_reg;
    assign m_valid   = out_valid_reg;
    assign m_hit     = out_reg.hit;
    assign m_cross_x = out_reg.cross_x;
    assign m_cross_y = out_reg.cross_y;

endmodule

// File: design/segment_intersection.sv
// Top level: segment pair intersection pipeline with its configuration register.
//
// Takes one segment pair per cycle while s_ready is high and returns one
// result per pair, in order. A request passes five stages of differences,
// cross products and the hit test, four stages that build the crossing-point
// numerators from split multiplies, a 25-stage restoring divider (one quotient
// bit per stage), and the output register. A skid stage behind the output
// register lets the pipe take requests in a downstream stall until a result
// is parked there; s_ready falls only while that skid entry is occupied.
// parallel_limit sits at byte address 0 of the APB port and resets to 66.
module segment_intersection import sgi_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_p1_x,
    input  logic signed [COORD_W-1:0] s_p1_y,
    input  logic signed [COORD_W-1:0] s_p2_x,
    input  logic signed [COORD_W-1:0] s_p2_y,
    input  logic signed [COORD_W-1:0] s_q1_x,
    input  logic signed [COORD_W-1:0] s_q1_y,
    input  logic signed [COORD_W-1:0] s_q2_x,
    input  logic signed [COORD_W-1:0] s_q2_y,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_hit,
    output logic signed [CROSS_W-1:0] m_cross_x,
    output logic signed [CROSS_W-1:0] m_cross_y
);

    logic [LIMIT_W-1:0] limit_next, limit_reg;
    logic               wr_limit, sel_limit, en;
    seg_pair_t          pair;
    cross_res_t         cres;
    div_stage_t         dsrc, dres;

    assign pready    = 1'b1;
    assign sel_limit = (paddr[ADDR_W-1:2] == REG_PARALLEL_LIMIT);
    assign wr_limit  = psel && penable && pwrite && sel_limit;
    assign limit_next = wr_limit ? pwdata[LIMIT_W-1:0] : limit_reg;
    assign prdata    = sel_limit ? DATA_W'(limit_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else begin
            limit_reg <= limit_next;
        end
    end

    always_comb begin
        pair.p1_x = s_p1_x;
        pair.p1_y = s_p1_y;
        pair.p2_x = s_p2_x;
        pair.p2_y = s_p2_y;
        pair.q1_x = s_q1_x;
        pair.q1_y = s_q1_y;
        pair.q2_x = s_q2_x;
        pair.q2_y = s_q2_y;
    end

    assign s_ready = en;

    sgi_cross u_cross (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_pair  (pair),
        .limit    (limit_reg),
        .res      (cres)
    );

    sgi_point u_point (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .c       (cres),
        .d       (dsrc)
    );

    sgi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .d_in    (dsrc),
        .d_out   (dres)
    );

    sgi_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .d         (dres),
        .en        (en),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_hit     (m_hit),
        .m_cross_x (m_cross_x),
        .m_cross_y (m_cross_y)
    );

endmodule

// File: design/sgi_checker.sv
// Port-level checks for the segment intersection block, bound to the top level.
module sgi_checker import sgi_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_hit,
    input logic signed [CROSS_W-1:0] m_cross_x,
    input logic signed [CROSS_W-1:0] m_cross_y
);

    // a miss never carries a point
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> (m_cross_x == '0) && (m_cross_y == '0))
        else $error("miss result with nonzero point");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // input side stops only after the output has been held off
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("s_ready fell without an output stall");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) &&
            $stable(m_cross_x) && $stable(m_cross_y))
        else $error("stalled result changed");

endmodule

bind segment_intersection sgi_checker u_sgi_checker (.*);
